// ===== rtl/tfp_pkg.sv =====
// Shared types and constants of the tab-separated field parser.
package tfp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_DATA_END = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DOT_END_ENABLE = 2'd0;
    localparam logic [1:0] REG_NUM_COLUMNS    = 2'd1;

    // Characters the parser reacts to
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    // Column counter and column count register
    localparam int COL_W  = 10;
    localparam int NCOL_W = 11;
    localparam logic [NCOL_W-1:0] MAX_COLUMNS = 11'd1024;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       field_byte;
        logic             field_null;
        logic [COL_W-1:0] column;
        logic             last;
    } result_t;

    // Results produced by one item: zero, one or two
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/tfp_step.sv =====
// Parser state and the per-byte decision logic of the field parser.
module tfp_step
    import tfp_pkg::*;
#(
    parameter int MAX_FIELD = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    input  logic              dot_end_enable,
    input  logic [NCOL_W-1:0] num_columns,
    output push_t             push
);

    localparam int LEN_W = $clog2(MAX_FIELD);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FIELD - 1);

    logic [COL_W-1:0] column_reg, column_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic             escape_reg, escape_next;
    logic             dot_reg, dot_next;
    logic             stopped_reg, stopped_next;

    logic [NCOL_W-1:0] columns_eff;
    logic [NCOL_W-1:0] column_inc;
    logic [COL_W-1:0]  column_wrap;
    logic [LEN_W-1:0]  length_inc;
    logic              is_sep;

    // Clamp column count to 1..1024 and compute the wrapped next column
    always_comb
    begin
        if (num_columns == '0)
            columns_eff = NCOL_W'(1);
        else if (num_columns > MAX_COLUMNS)
            columns_eff = MAX_COLUMNS;
        else
            columns_eff = num_columns;
        column_inc  = NCOL_W'(column_reg) + NCOL_W'(1);
        column_wrap = (column_inc >= columns_eff) ? '0 : column_inc[COL_W-1:0];
        length_inc  = length_reg + LEN_W'(1);
        is_sep      = (data_byte == CHAR_TAB) || (data_byte == CHAR_NEWLINE);
    end

    // Decide results and next state for the item in the input register
    always_comb
    begin
        column_next  = column_reg;
        length_next  = length_reg;
        escape_next  = escape_reg;
        dot_next     = dot_reg;
        stopped_next = stopped_reg;

        push.count             = 2'd0;
        push.first.kind        = KIND_BYTE;
        push.first.field_byte  = '0;
        push.first.field_null  = 1'b0;
        push.first.column      = column_reg;
        push.first.last        = 1'b1;
        push.second.kind       = KIND_BYTE;
        push.second.field_byte = '0;
        push.second.field_null = 1'b0;
        push.second.column     = column_reg;
        push.second.last       = 1'b1;

        if (fire && !stopped_reg)
        begin
            priority if (end_of_input)
            begin
                push.count      = 2'd1;
                push.first.kind = KIND_DATA_END;
                stopped_next    = 1'b1;
                escape_next     = 1'b0;
                dot_next        = 1'b0;
            end
            else if (dot_reg)
            begin
                // Held dot: newline ends data, else the dot becomes a field byte.
                // The field is empty here, so two bytes stay below the limit.
                dot_next = 1'b0;
                if (data_byte == CHAR_NEWLINE)
                begin
                    push.count      = 2'd1;
                    push.first.kind = KIND_DATA_END;
                    stopped_next    = 1'b1;
                end
                else
                begin
                    push.count             = 2'd2;
                    push.first.kind        = KIND_BYTE;
                    push.first.field_byte  = CHAR_DOT;
                    push.first.last        = 1'b0;
                    if (data_byte == CHAR_TAB)
                    begin
                        push.second.kind = KIND_END;
                        length_next      = '0;
                        column_next      = column_wrap;
                    end
                    else
                    begin
                        push.second.kind       = KIND_BYTE;
                        push.second.field_byte = data_byte;
                        length_next            = length_reg + LEN_W'(2);
                    end
                end
            end
            else if (escape_reg || (!is_sep && data_byte != CHAR_BACKSLASH &&
                     !(dot_end_enable && column_reg == '0 && length_reg == '0 &&
                       data_byte == CHAR_DOT)))
            begin
                // Store one field byte; raise overflow at the length limit
                escape_next           = 1'b0;
                push.count            = 2'd1;
                push.first.kind       = KIND_BYTE;
                push.first.field_byte = data_byte;
                length_next           = length_inc;
                if (length_inc >= LEN_LIMIT)
                begin
                    push.count       = 2'd2;
                    push.first.last  = 1'b0;
                    push.second.kind = KIND_OVERFLOW;
                    stopped_next     = 1'b1;
                end
            end
            else if (data_byte == CHAR_DOT)
            begin
                dot_next = 1'b1;
            end
            else if (data_byte == CHAR_BACKSLASH)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                // Tab or newline closes the field
                push.count            = 2'd1;
                push.first.kind       = KIND_END;
                push.first.field_null = (length_reg == '0);
                length_next           = '0;
                column_next           = column_wrap;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            length_reg  <= '0;
            escape_reg  <= 1'b0;
            dot_reg     <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            column_reg  <= column_next;
            length_reg  <= length_next;
            escape_reg  <= escape_next;
            dot_reg     <= dot_next;
            stopped_reg <= stopped_next;
        end
    end

    // Once stopped, the parser stays stopped until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("tfp_step: stopped flag cleared without reset");

    // A running field never reaches the overflow limit
    assert property (@(posedge clk) disable iff (!rst_n)
        !stopped_reg |-> (length_reg < LEN_LIMIT))
        else $error("tfp_step: field length at limit while running");

    // Held dot and pending escape never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        !(dot_reg && escape_reg))
        else $error("tfp_step: held dot and escape both pending");

endmodule

// ===== rtl/tfp_out_queue.sv =====
// Result queue of the field parser: takes up to two results a cycle, gives one unless stalled.
module tfp_out_queue
    import tfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_second;

    // Accept new work only when two free entries remain
    assign room          = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid     = (count_reg != '0);
    assign head          = entry_reg[rd_ptr_reg];
    assign pop           = out_valid && !out_stall;
    assign wr_ptr_second = wr_ptr_reg + QPTR_W'(1);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the results of one item
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_second] <= push.second;
    end

    // Fill count never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("tfp_out_queue: fill count beyond depth");

endmodule

// ===== rtl/tsv_field_parser_unit.sv =====
// Top level of the tab-separated field parser.
//
// One byte of a tab-separated text stream, or an end-of-input mark, is
// taken per transfer and turned into field bytes, field ends (with a null
// flag and the column number), an end-of-data mark or an overflow error.
// An input transfer can be taken every cycle unless the input stalls; each
// item waits in the input register, is decoded in a single pass and lands
// in a four-entry result queue. The output side gives one result a cycle
// unless the output stalls: two-result items (a held leading dot followed
// by a byte other than newline, or the byte that hits the field length
// limit) give them one after the other, and the input stalls while the
// queue has fewer than two free entries. After a data end or an overflow
// error the block takes more bytes but gives no results until reset. The
// user must make configuration writes only while idle; not enforced.
module tsv_field_parser_unit
    import tfp_pkg::*;
#(
    parameter int MAX_FIELD = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_addr,
    input  logic [NCOL_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        field_byte,
    output logic              field_null,
    output logic [COL_W-1:0]  column,
    output logic              last
);

    logic              dot_end_enable_reg;
    logic [NCOL_W-1:0] num_columns_reg;
    logic              hold_valid_reg;
    logic [7:0]        hold_byte_reg;
    logic              hold_eoi_reg;
    logic              room;
    logic              advance;
    push_t             push;
    result_t           head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_end_enable_reg <= 1'b0;
            num_columns_reg    <= NCOL_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_DOT_END_ENABLE: dot_end_enable_reg <= cfg_wdata[0];
                REG_NUM_COLUMNS:    num_columns_reg    <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Input register: move on when the queue has room for two results
    assign advance  = hold_valid_reg && room;
    assign in_stall = hold_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (!in_stall)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_byte_reg <= data_byte;
            hold_eoi_reg  <= end_of_input;
        end
    end

    tfp_step #(
        .MAX_FIELD (MAX_FIELD)
    ) u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .data_byte      (hold_byte_reg),
        .end_of_input   (hold_eoi_reg),
        .dot_end_enable (dot_end_enable_reg),
        .num_columns    (num_columns_reg),
        .push           (push)
    );

    tfp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Drive result fields from the queue head
    assign kind       = head.kind;
    assign field_byte = head.field_byte;
    assign field_null = head.field_null;
    assign column     = head.column;
    assign last       = head.last;

    // Results are only pushed for an item leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> advance)
        else $error("tsv_field_parser_unit: results without an item");

endmodule

// ===== tb/tsv_field_parser_checker.sv =====
// Result checker for the tab-separated field parser: field-splitting predictor and compare.
module tsv_field_parser_checker
    import tfp_pkg::*;
#(
    parameter int MAX_FIELD = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_addr,
    input  logic [NCOL_W-1:0] cfg_wdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        kind,
    input  logic [7:0]        field_byte,
    input  logic              field_null,
    input  logic [COL_W-1:0]  column,
    input  logic              last,
    output int                fail_count,
    output int                due_count,
    output int                checked_count,
    output logic              dot_held
);

    // Register copies
    logic              dot_end_on;
    logic [NCOL_W-1:0] col_count;

    // Parser state as predicted
    int unsigned       col_idx;
    int unsigned       fld_len;
    logic              escape_on;
    logic              dot_on;
    logic              halted;

    // Results still owed by the block, oldest first
    result_t           due_results[$];
    // Results of the transfer being parsed
    result_t           step_results[$];

    // Clamp the column count to the supported range
    function automatic int unsigned columns_in_row();
        if (col_count == '0)
            return 1;
        if (col_count > MAX_COLUMNS)
            return MAX_COLUMNS;
        return col_count;
    endfunction

    // Record one result of the current transfer
    function automatic void add_result(logic [1:0] k, logic [7:0] b, logic nul);
        result_t r;
        r.kind       = k;
        r.field_byte = b;
        r.field_null = nul;
        r.column     = col_idx[COL_W-1:0];
        r.last       = 1'b0;
        step_results.push_back(r);
    endfunction

    // Close the current field and advance the column counter
    function automatic void close_field();
        add_result(KIND_END, 8'h00, fld_len == 0);
        fld_len = 0;
        if (col_idx + 1 >= columns_in_row())
            col_idx = 0;
        else
            col_idx = col_idx + 1;
    endfunction

    // Store one field byte; stop on reaching the length limit
    function automatic void keep_byte(logic [7:0] b);
        add_result(KIND_BYTE, b, 1'b0);
        fld_len++;
        if (fld_len >= MAX_FIELD - 1)
        begin
            add_result(KIND_OVERFLOW, 8'h00, 1'b0);
            halted = 1'b1;
        end
    endfunction

    // Parse one input transfer and queue the results it owes
    function automatic void parse_byte(logic [7:0] b, logic eoi);
        result_t r;
        step_results.delete();
        if (!halted)
        begin
            if (eoi)
            begin
                add_result(KIND_DATA_END, 8'h00, 1'b0);
                halted    = 1'b1;
                escape_on = 1'b0;
                dot_on    = 1'b0;
            end
            else if (dot_on)
            begin
                dot_on = 1'b0;
                if (b == CHAR_NEWLINE)
                begin
                    add_result(KIND_DATA_END, 8'h00, 1'b0);
                    halted = 1'b1;
                end
                else
                begin
                    keep_byte(CHAR_DOT);
                    if (!halted)
                    begin
                        if (b == CHAR_TAB)
                            close_field();
                        else
                            keep_byte(b);
                    end
                end
            end
            else if (escape_on)
            begin
                escape_on = 1'b0;
                keep_byte(b);
            end
            else if (dot_end_on && col_idx == 0 && fld_len == 0 && b == CHAR_DOT)
            begin
                dot_on = 1'b1;
            end
            else if (b == CHAR_BACKSLASH)
            begin
                escape_on = 1'b1;
            end
            else if (b == CHAR_TAB || b == CHAR_NEWLINE)
            begin
                close_field();
            end
            else
            begin
                keep_byte(b);
            end
        end
        foreach (step_results[i])
        begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            due_results.push_back(r);
        end
    endfunction

    // Track registers, predict on input transfers, compare output transfers
    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            dot_end_on    = 1'b0;
            col_count     = 11'd1;
            col_idx       = 0;
            fld_len       = 0;
            escape_on     = 1'b0;
            dot_on        = 1'b0;
            halted        = 1'b0;
            fail_count    = 0;
            checked_count = 0;
            due_results.delete();
        end
        else
        begin
            // Compare the output transfer with the oldest expectation
            if (out_valid && !out_stall)
            begin
                seen.kind       = kind;
                seen.field_byte = field_byte;
                seen.field_null = field_null;
                seen.column     = column;
                seen.last       = last;
                checked_count++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected result: expected none, got kind %0d",
                              " byte %02h null %0b column %0d last %0b"},
                             $time, seen.kind, seen.field_byte, seen.field_null,
                             seen.column, seen.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (seen.kind !== want.kind || seen.field_byte !== want.field_byte ||
                        seen.field_null !== want.field_null || seen.column !== want.column ||
                        seen.last !== want.last)
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch: expected kind %0d byte %02h null %0b",
                                  " column %0d last %0b, got kind %0d byte %02h null %0b",
                                  " column %0d last %0b"},
                                 $time, want.kind, want.field_byte, want.field_null,
                                 want.column, want.last, seen.kind, seen.field_byte,
                                 seen.field_null, seen.column, seen.last);
                    end
                end
            end

            // Mirror register writes; other indexes are ignored
            if (cfg_write)
            begin
                case (cfg_addr)
                    REG_DOT_END_ENABLE: dot_end_on = cfg_wdata[0];
                    REG_NUM_COLUMNS:    col_count  = cfg_wdata;
                    default: ;
                endcase
            end

            // Predict the input transfer
            if (in_valid && !in_stall)
                parse_byte(data_byte, end_of_input);
        end
        due_count = due_results.size();
        dot_held  = dot_on && !halted;
    end

endmodule

// ===== tb/tb_tsv_field_parser_unit.sv =====
// Testbench top for the tab-separated field parser: stimulus, idling and verdict.
module tb_tsv_field_parser_unit;
    import tfp_pkg::*;

    localparam int FIELD_MAX   = 2048;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 56;

    // Register indexes the block does not implement
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    // Ways the stream is brought to a stop
    typedef enum int {
        STOP_EOI_IN_FIELD,
        STOP_EOI_AFTER_ESCAPE,
        STOP_DOT_NEWLINE,
        STOP_EOI_AFTER_DOT,
        STOP_OVERFLOW
    } stop_mode_t;

    localparam logic [7:0] SPECIAL_BYTES [4] = '{CHAR_TAB, CHAR_NEWLINE, CHAR_DOT, CHAR_BACKSLASH};

    // Opening sequence, parsed with the end mark on and three columns
    localparam logic [7:0] OPENING_BYTES [25] = '{
        CHAR_DOT, 8'h61, CHAR_TAB, CHAR_TAB, CHAR_BACKSLASH,
        CHAR_TAB, CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_DOT, CHAR_NEWLINE,
        CHAR_DOT, CHAR_TAB, 8'h00, 8'hFF, CHAR_NEWLINE,
        CHAR_DOT, CHAR_NEWLINE, CHAR_BACKSLASH, CHAR_NEWLINE, CHAR_TAB,
        CHAR_TAB, CHAR_NEWLINE, CHAR_BACKSLASH, CHAR_DOT, CHAR_NEWLINE
    };

    // Register settings per random phase
    localparam logic [NCOL_W-1:0] NCOL_PLAN [PHASES] = '{
        11'd1024, 11'd4, 11'd1, 11'd0, 11'd2047, 11'd2, 11'd1025, 11'd5
    };
    localparam logic DOT_PLAN [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [1:0]        cfg_addr;
    logic [NCOL_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              end_of_input;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        kind;
    logic [7:0]        field_byte;
    logic              field_null;
    logic [COL_W-1:0]  column;
    logic              last;

    int                fail_count;
    int                due_count;
    int                checked_count;
    logic              dot_held;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_asks      = 0;
    int                items_sent     = 0;
    int                cycle_count;
    logic [NCOL_W-1:0] ncols_set;

    tsv_field_parser_unit #(
        .MAX_FIELD (FIELD_MAX)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .field_byte   (field_byte),
        .field_null   (field_null),
        .column       (column),
        .last         (last)
    );

    tsv_field_parser_checker #(
        .MAX_FIELD (FIELD_MAX)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .field_byte    (field_byte),
        .field_null    (field_null),
        .column        (column),
        .last          (last),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .checked_count (checked_count),
        .dot_held      (dot_held)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a run that hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when asked
    initial
    begin
        int hold_done;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_done)
            begin
                hold_done = hold_asks;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Offer one input transfer and hold it until taken
    task automatic offer(input logic [7:0] b, input logic eoi);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
            @(negedge clk);
        end
        items_sent++;
    endtask

    // Send a text byte, never closing the data by accident
    task automatic send_text(input logic [7:0] b);
        if (dot_held && b == CHAR_NEWLINE)
            offer(CHAR_TAB, 1'b0);
        else
            offer(b, 1'b0);
    endtask

    // Write one register, then drop the enable
    task automatic write_reg(input logic [1:0] idx, input logic [NCOL_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until the block has gone idle
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [7:0]        b;
        logic [NCOL_W-1:0] val;
        int                phase_start;
        int                row_len;
        int                fld_size;
        int                pick;
        int                stored;
        stop_mode_t        stop_mode;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        end_of_input <= 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Opening sequence: held dots, escapes, empty fields, wrap
        write_reg(REG_DOT_END_ENABLE, 11'd1);
        write_reg(REG_NUM_COLUMNS, 11'd3);
        foreach (OPENING_BYTES[i])
            send_text(OPENING_BYTES[i]);

        // Random phases: mostly rows of fields, some raw noise
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            val    = NCOL_W'($urandom_range(0, 2047));
            val[0] = DOT_PLAN[p];
            write_reg(REG_DOT_END_ENABLE, val);
            ncols_set = NCOL_PLAN[p];
            if (p == PHASES - 1)
                ncols_set = NCOL_W'($urandom_range(2, 8));
            write_reg(REG_NUM_COLUMNS, ncols_set);
            if (p % 3 == 0)
                write_reg((p % 2 != 0) ? REG_SPARE_3 : REG_SPARE_2,
                          NCOL_W'($urandom_range(0, 2047)));
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            // Back-pressure the output while the input keeps coming
            if (p == 0 || p == 4)
                hold_asks++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    repeat ($urandom_range(1, 4))
                        send_text(8'($urandom_range(0, 255)));
                end
                else
                begin
                    if (ncols_set == 0)
                        row_len = 1;
                    else if (ncols_set > 8)
                        row_len = $urandom_range(1, 12);
                    else
                        row_len = ncols_set;
                    for (int f = 0; f < row_len; f++)
                    begin
                        fld_size = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                               : $urandom_range(0, 5);
                        for (int c = 0; c < fld_size; c++)
                        begin
                            pick = $urandom_range(0, 99);
                            if (pick < 8)
                            begin
                                send_text(CHAR_BACKSLASH);
                                if ($urandom_range(0, 1) != 0)
                                    send_text(SPECIAL_BYTES[$urandom_range(0, 3)]);
                                else
                                    send_text(8'($urandom_range(0, 255)));
                            end
                            else if (pick < 16 || (c == 0 && pick < 30))
                            begin
                                send_text(CHAR_DOT);
                            end
                            else
                            begin
                                b = 8'($urandom_range(0, 255));
                                if (b == CHAR_TAB || b == CHAR_NEWLINE || b == CHAR_BACKSLASH)
                                    b = b + 8'h20;
                                send_text(b);
                            end
                        end
                        send_text((f == row_len - 1) ? CHAR_NEWLINE : CHAR_TAB);
                    end
                end
            end
        end

        // Bring the stream to its one stop
        drain();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        stop_mode = stop_mode_t'($urandom_range(0, 4));
        case (stop_mode)
            STOP_EOI_IN_FIELD:
            begin
                send_text(8'h78);
                send_text(8'h79);
                offer(8'($urandom_range(0, 255)), 1'b1);
            end
            STOP_EOI_AFTER_ESCAPE:
            begin
                send_text(8'h78);
                send_text(CHAR_BACKSLASH);
                offer(8'($urandom_range(0, 255)), 1'b1);
            end
            STOP_DOT_NEWLINE, STOP_EOI_AFTER_DOT:
            begin
                write_reg(REG_DOT_END_ENABLE, 11'd1);
                write_reg(REG_NUM_COLUMNS, 11'd1);
                send_text(8'h7A);
                send_text(CHAR_NEWLINE);
                offer(CHAR_DOT, 1'b0);
                if (stop_mode == STOP_DOT_NEWLINE)
                    offer(CHAR_NEWLINE, 1'b0);
                else
                    offer(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                // Fill one field up to the length limit
                send_text(8'h7A);
                send_text(CHAR_NEWLINE);
                stored = 0;
                while (stored < FIELD_MAX - 1)
                begin
                    if ($urandom_range(0, 99) < 5)
                    begin
                        offer(CHAR_BACKSLASH, 1'b0);
                        offer(8'($urandom_range(0, 255)), 1'b0);
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CHAR_TAB || b == CHAR_NEWLINE || b == CHAR_BACKSLASH ||
                            b == CHAR_DOT)
                            b = b + 8'h20;
                        offer(b, 1'b0);
                    end
                    stored++;
                end
            end
        endcase

        // Once stopped, further transfers give nothing
        repeat (12)
            offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        drain();
        repeat (12) @(negedge clk);

        $display("Run covered %0d input transfers and %0d output results over %0d settings,",
                 items_sent, checked_count, PHASES + 1);
        $display("stopped by %s; %0d failures seen.", stop_mode.name(), fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
